// File: src/ckdil_pkg.sv
// ----------------------------------------------------------------------------
// Colour-keyed dilation package
// Sizes, register indexes, record types and helpers shared by the block.
// ----------------------------------------------------------------------------
package ckdil_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_BORDER = 16;

  localparam int SIZE_W   = 11;
  localparam int BORDER_W = 5;
  localparam int COLOR_W  = 24;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 3;

  localparam int COL_W = $clog2(MAX_WIDTH);
  // Rows run past the frame while the tail drains.
  localparam int ROW_W = $clog2(MAX_HEIGHT + 2 * MAX_BORDER) + 1;
  localparam int POS_W = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_BORDER * MAX_WIDTH
                                + MAX_BORDER) + 1;
  localparam int DLY_W = $clog2(MAX_BORDER * MAX_WIDTH + MAX_BORDER + 1);
  localparam int DLY_DEPTH = 2 ** DLY_W;

  localparam int RUN_W = 6;
  localparam logic [RUN_W-1:0] RUN_NONE = '1;

  localparam int ROWLAST_N  = 32;
  localparam int ROWLAST_AW = $clog2(ROWLAST_N);

  localparam int FIFO_N  = 4;
  localparam int FIFO_AW = $clog2(FIFO_N);
  localparam int FIFO_CW = FIFO_AW + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_BORDER_SIZE  = 3'd2,
    REG_ENABLE       = 3'd3,
    REG_TARGET_COLOR = 3'd4,
    REG_PAINT_COLOR  = 3'd5
  } reg_index_t;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  typedef struct packed {
    logic             valid;
    logic [COL_W-1:0] col;
  } last_key_t;

  typedef struct packed {
    logic [COLOR_W-1:0] pixel;
    logic               painted;
    logic               frame_last;
  } result_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] limit);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > limit) begin
      r = limit;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// File: src/ckdil_ifs.sv
// ----------------------------------------------------------------------------
// Colour-keyed dilation channels
// Valid/ready channels for incoming pixel words and outgoing result words.
// ----------------------------------------------------------------------------
interface ckdil_pixel_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] byte_first;
  logic [7:0] byte_second;
  logic [7:0] byte_third;

  modport source (output valid, op, byte_first, byte_second, byte_third, input ready);
  modport sink   (input valid, op, byte_first, byte_second, byte_third, output ready);
endinterface

interface ckdil_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_first;
  logic [7:0] out_second;
  logic [7:0] out_third;
  logic       painted;
  logic       frame_last;

  modport source (output valid, out_first, out_second, out_third, painted, frame_last,
                  input ready);
  modport sink   (input valid, out_first, out_second, out_third, painted, frame_last,
                  output ready);
endinterface

// File: src/ckdil_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ckdil_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/color_keyed_square_dilation.sv
// ----------------------------------------------------------------------------
// Colour-keyed square dilation
// Repaints the square neighbourhood of key-coloured pixels in a raster stream.
// Order: the result for pixel n is formed in stage B after pixel n + b*W + b
//   is accepted (b = border, W = width), or after pixel n itself when b = 0.
//   After the last pixel, one flush word releases one result.
// Throughput: one word per cycle while the output FIFO has room and no hold applies,
//   set by one run-length RAM read-modify-write per column and one delay RAM write/read.
// Reset: synchronous; clears control and restores register defaults. The RAMs
//   are not cleared: every entry is written in a frame before it is read.
// ----------------------------------------------------------------------------
module color_keyed_square_dilation (
  input  logic                                    clk,
  input  logic                                    rst,
  ckdil_pixel_if.sink                             pixels,
  ckdil_result_if.source                          results,
  input  logic                                    cfg_write,
  input  logic [ckdil_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ckdil_pkg::CFG_W-1:0]             cfg_data
);

  localparam int SW = ckdil_pkg::SIZE_W;
  localparam int BW = ckdil_pkg::BORDER_W;
  localparam int CW = ckdil_pkg::COL_W;
  localparam int RW = ckdil_pkg::ROW_W;
  localparam int PW = ckdil_pkg::POS_W;
  localparam int DW = ckdil_pkg::DLY_W;
  localparam int KW = ckdil_pkg::COLOR_W;
  localparam int NW = ckdil_pkg::RUN_W;
  localparam int LW = ckdil_pkg::ROWLAST_AW;

  // Configuration registers
  logic [SW-1:0] cfg_width, cfg_height;
  logic [BW-1:0] cfg_border;
  logic          cfg_enable;
  logic [KW-1:0] cfg_target, cfg_paint;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= SW'(1);
      cfg_height <= SW'(1);
      cfg_border <= '0;
      cfg_enable <= 1'b0;
      cfg_target <= KW'(24'hFF0000);
      cfg_paint  <= KW'(24'h0000FF);
    end else if (cfg_write) begin
      case (ckdil_pkg::reg_index_t'(cfg_index))
        ckdil_pkg::REG_IMAGE_WIDTH:  cfg_width  <= cfg_data[SW-1:0];
        ckdil_pkg::REG_IMAGE_HEIGHT: cfg_height <= cfg_data[SW-1:0];
        ckdil_pkg::REG_BORDER_SIZE:  cfg_border <= cfg_data[BW-1:0];
        ckdil_pkg::REG_ENABLE:       cfg_enable <= cfg_data[0];
        ckdil_pkg::REG_TARGET_COLOR: cfg_target <= cfg_data[KW-1:0];
        ckdil_pkg::REG_PAINT_COLOR:  cfg_paint  <= cfg_data[KW-1:0];
        default: ;
      endcase
    end
  end

  // Frame settings and counters
  logic          active;
  logic [SW-1:0] fw;
  logic [BW-1:0] fb;
  logic [KW-1:0] fkey, fpaint;
  logic [PW-1:0] total;
  logic [DW-1:0] dly;
  logic [PW-1:0] p, q, ev;
  logic [RW-1:0] pr;
  logic [CW-1:0] pc, orow, ocol;

  // Stage B registers
  logic          bv, b_key, b_row0, b_last_col, b_emit, b_wrap, b_fwd, b_frame_last;
  logic [CW-1:0] b_col, b_ocol;
  logic [LW-1:0] b_row_mod, b_oi_mod;
  logic [NW-1:0] b_fwdval;
  logic [KW-1:0] b_pix;

  logic [ckdil_pkg::FIFO_CW-1:0] fifo_cnt;

  // New-frame settings
  logic [SW-1:0] w_new, h_new;
  logic [BW-1:0] b_new;
  logic [PW-1:0] total_new;
  logic [DW-1:0] dly_new;
  logic [2*SW-1:0] area;
  logic [SW+BW:0]  dprod;

  always_comb begin
    w_new = ckdil_pkg::clamp_size(cfg_width, SW'(ckdil_pkg::MAX_WIDTH));
    h_new = ckdil_pkg::clamp_size(cfg_height, SW'(ckdil_pkg::MAX_HEIGHT));
    if (!cfg_enable) begin
      b_new = '0;
    end else if (cfg_border > BW'(ckdil_pkg::MAX_BORDER)) begin
      b_new = BW'(ckdil_pkg::MAX_BORDER);
    end else begin
      b_new = cfg_border;
    end
    area      = (2*SW)'(w_new) * (2*SW)'(h_new);
    total_new = area[PW-1:0];
    dprod     = (SW+BW+1)'(b_new) * (SW+BW+1)'(w_new) + (SW+BW+1)'(b_new);
    dly_new   = dprod[DW-1:0];
  end

  // Issue control
  logic [KW-1:0] in_pix;
  logic room, hold, acc, is_pix, start, real_pix, tail_item, seq_go, issue;
  logic a_emit, a_event, a_key, a_last_col, a_frame_last, a_wrap, a_fwd;
  logic [SW-1:0] fw_e;
  logic [BW-1:0] fb_e;
  logic [PW-1:0] total_e, a_p, a_q;
  logic [DW-1:0] dly_e;
  logic [RW-1:0] a_pr;
  logic [CW-1:0] a_pc, a_orow, a_ocol;
  logic [PW:0]   end_pos;
  logic [PW-1:0] rd_pos;
  logic [NW-1:0] run_new;

  assign in_pix = {pixels.byte_third, pixels.byte_second, pixels.byte_first};
  assign room   = (fifo_cnt + ckdil_pkg::FIFO_CW'(bv)) < ckdil_pkg::FIFO_CW'(ckdil_pkg::FIFO_N);
  // Between frames, wait for the final result of the old frame to leave stage B.
  assign hold   = (active && (ev == total)) || (!active && bv);
  assign pixels.ready = room && !hold;
  assign acc    = pixels.valid && pixels.ready;
  assign is_pix = (ckdil_pkg::op_t'(pixels.op) == ckdil_pkg::OP_PIXEL);
  assign start     = acc && is_pix && !active;
  assign real_pix  = acc && is_pix && active && (p < total);
  assign tail_item = acc && active && (p >= total);
  assign end_pos   = {1'b0, total} + (PW+1)'(dly);
  // After the last pixel, positions are stepped internally; each result waits
  // for the word that releases it.
  assign seq_go = active && (p >= total) && ({1'b0, p} < end_pos) && room &&
                  ((p < PW'(dly)) || (ev > q));
  assign issue  = start || real_pix || seq_go;

  always_comb begin
    fw_e    = start ? w_new : fw;
    fb_e    = start ? b_new : fb;
    total_e = start ? total_new : total;
    dly_e   = start ? dly_new : dly;
    a_p     = start ? '0 : p;
    a_pr    = start ? '0 : pr;
    a_pc    = start ? '0 : pc;
    a_q     = start ? '0 : q;
    a_orow  = start ? '0 : orow;
    a_ocol  = start ? '0 : ocol;
    a_emit  = (a_p >= PW'(dly_e));
    if (start || real_pix) begin
      a_event = a_emit || (a_p == total_e - PW'(1));
    end else begin
      a_event = tail_item;
    end
    a_key        = (start || real_pix) && (in_pix == (start ? cfg_target : fkey));
    a_last_col   = ({1'b0, a_pc} == fw_e - SW'(1));
    a_frame_last = (a_q == total_e - PW'(1));
    a_wrap       = (({1'b0, a_ocol} + SW'(fb_e)) >= fw_e);
    a_fwd        = bv && (b_col == a_pc);
    rd_pos       = a_p - PW'(dly_e);
  end

  // Delay RAM: the pixel at position p is read back at position p + D.
  logic [KW-1:0] px_rdata;

  ckdil_ram #(.WIDTH(KW), .DEPTH(ckdil_pkg::DLY_DEPTH)) u_pixel_ram (
    .clk   (clk),
    .we    (start || real_pix),
    .waddr (a_p[DW-1:0]),
    .wdata (in_pix),
    .raddr (rd_pos[DW-1:0]),
    .rdata (px_rdata)
  );

  // Column run RAM: rows since the last key in each column.
  logic [NW-1:0] rs_rdata;

  ckdil_ram #(.WIDTH(NW), .DEPTH(ckdil_pkg::MAX_WIDTH)) u_run_ram (
    .clk   (clk),
    .we    (bv),
    .waddr (b_col),
    .wdata (run_new),
    .raddr (a_pc),
    .rdata (rs_rdata)
  );

  // Counter update
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      fw     <= SW'(1);
      fb     <= '0;
      total  <= PW'(1);
      dly    <= '0;
      p      <= '0;
      pr     <= '0;
      pc     <= '0;
      q      <= '0;
      orow   <= '0;
      ocol   <= '0;
      ev     <= '0;
    end else begin
      // The frame ends when its final result is issued, even on its first pixel.
      if (issue && a_emit && a_frame_last) begin
        active <= 1'b0;
      end else if (start) begin
        active <= 1'b1;
      end
      if (start) begin
        fw     <= w_new;
        fb     <= b_new;
        fkey   <= cfg_target;
        fpaint <= cfg_paint;
        total  <= total_new;
        dly    <= dly_new;
        ev     <= PW'(a_event);
      end else if (a_event) begin
        ev <= ev + PW'(1);
      end
      if (issue) begin
        p <= a_p + PW'(1);
        if (a_last_col) begin
          pc <= '0;
          pr <= a_pr + RW'(1);
        end else begin
          pc <= a_pc + CW'(1);
          pr <= a_pr;
        end
        if (a_emit) begin
          q <= a_q + PW'(1);
          if ({1'b0, a_ocol} == fw_e - SW'(1)) begin
            ocol <= '0;
            orow <= a_orow + CW'(1);
          end else begin
            ocol <= a_ocol + CW'(1);
            orow <= a_orow;
          end
        end else begin
          q    <= a_q;
          ocol <= a_ocol;
          orow <= a_orow;
        end
      end
    end
  end

  // Stage B pipeline register
  always_ff @(posedge clk) begin
    if (rst) begin
      bv <= 1'b0;
    end else begin
      bv <= issue;
    end
    b_key        <= a_key;
    b_row0       <= (a_pr == '0);
    b_last_col   <= a_last_col;
    b_emit       <= a_emit;
    b_wrap       <= a_wrap;
    b_fwd        <= a_fwd;
    b_fwdval     <= run_new;
    b_frame_last <= a_frame_last;
    b_col        <= a_pc;
    b_ocol       <= a_ocol;
    b_row_mod    <= a_pr[LW-1:0];
    b_oi_mod     <= a_orow[LW-1:0] + LW'(fb_e);
    b_pix        <= in_pix;
  end

  // Stage B: vertical run update, horizontal last-key tracking, paint decision
  ckdil_pkg::last_key_t lv, lv_new, rl;
  ckdil_pkg::last_key_t rowlast [ckdil_pkg::ROWLAST_N];
  logic [NW-1:0] run_base;
  logic          v, mark, painted;
  logic [KW-1:0] pix, res_pix;

  always_comb begin
    if (b_row0) begin
      run_base = ckdil_pkg::RUN_NONE;
    end else if (b_fwd) begin
      run_base = b_fwdval;
    end else begin
      run_base = rs_rdata;
    end
    if (b_key) begin
      run_new = '0;
    end else if (run_base == ckdil_pkg::RUN_NONE) begin
      run_new = ckdil_pkg::RUN_NONE;
    end else begin
      run_new = run_base + NW'(1);
    end
    // A key lies within 2b rows ending at this one.
    v = (run_new < {fb, 1'b0});
    if (v) begin
      lv_new = '{valid: 1'b1, col: b_col};
    end else if (b_col == '0) begin
      lv_new = '{valid: 1'b0, col: '0};
    end else begin
      lv_new = lv;
    end
    rl = rowlast[b_oi_mod];
    // Near the right edge the window is clipped, so the summary of the whole row is used.
    if (b_wrap) begin
      mark = rl.valid && (({1'b0, rl.col} + SW'(fb)) > {1'b0, b_ocol});
    end else begin
      mark = lv_new.valid && (({1'b0, lv_new.col} + SW'({fb, 1'b0})) > {1'b0, b_col});
    end
    pix     = (fb == '0) ? b_pix : px_rdata;
    painted = (fb != '0) && (pix != fkey) && mark;
    res_pix = painted ? fpaint : pix;
  end

  always_ff @(posedge clk) begin
    if (bv) begin
      lv <= lv_new;
      if (b_last_col) begin
        rowlast[b_row_mod] <= lv_new;
      end
    end
  end

  // Output FIFO
  ckdil_pkg::result_t fifo_mem [ckdil_pkg::FIFO_N];
  ckdil_pkg::result_t head;
  logic [ckdil_pkg::FIFO_AW-1:0] fifo_rd, fifo_wr;
  logic push, pop;

  assign push = bv && b_emit;
  assign pop  = results.valid && results.ready;
  assign head = fifo_mem[fifo_rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_rd  <= '0;
      fifo_wr  <= '0;
      fifo_cnt <= '0;
    end else begin
      if (push) begin
        fifo_wr <= fifo_wr + ckdil_pkg::FIFO_AW'(1);
      end
      if (pop) begin
        fifo_rd <= fifo_rd + ckdil_pkg::FIFO_AW'(1);
      end
      if (push && !pop) begin
        fifo_cnt <= fifo_cnt + ckdil_pkg::FIFO_CW'(1);
      end else if (pop && !push) begin
        fifo_cnt <= fifo_cnt - ckdil_pkg::FIFO_CW'(1);
      end
    end
    if (push) begin
      fifo_mem[fifo_wr] <= '{pixel: res_pix, painted: painted, frame_last: b_frame_last};
    end
  end

  assign results.valid      = (fifo_cnt != '0);
  assign results.out_first  = head.pixel[7:0];
  assign results.out_second = head.pixel[15:8];
  assign results.out_third  = head.pixel[23:16];
  assign results.painted    = head.painted;
  assign results.frame_last = head.frame_last;

endmodule
